/* sv/plid_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plid_pkg
// Types and codes shared by the positional insert/delete list.
// ----------------------------------------------------------------------------
package plid_pkg;

   localparam logic [1:0] OP_READ   = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_DELETE = 2'd2;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_FULL   = 2'd1;
   localparam logic [1:0] ST_EMPTY  = 2'd2;
   localparam logic [1:0] ST_BADPOS = 2'd3;

   localparam int GROUP_SIZE = 64;

   typedef struct packed {
      logic [1:0]         opcode;
      logic [7:0]         position;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] read_value;
      logic [7:0]         entry_count;
   } rsp_type;

   typedef struct packed {
      logic ins;
      logic del;
   } shift_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_GATHER,
      S_COLLECT
   } state_type;

endpackage

/* sv/plid_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plid_cell
// One list slot: loads, takes a neighbor's word, or holds, and offers its word
// to the read gather when the read position names it.
// ----------------------------------------------------------------------------
module plid_cell #(
   parameter int PW    = 8,
   parameter int INDEX = 0
) (
   input  logic                clock,
   input  plid_pkg::shift_type shift,
   input  logic [PW-1:0]       pos,
   input  logic [31:0]         value,
   input  logic [31:0]         prev_data,
   input  logic [31:0]         next_data,
   input  logic [PW-1:0]       rd_pos,
   output logic [31:0]         data,
   output logic [31:0]         rd_data
);

   localparam logic [PW-1:0] MY_INDEX = PW'(INDEX);

   logic [31:0] data_ff;
   logic [31:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (shift.ins) begin
         if (MY_INDEX > pos) begin
            data_in = prev_data;
         end else if (MY_INDEX == pos) begin
            data_in = value;
         end
      end else if (shift.del) begin
         if (MY_INDEX >= pos) begin
            data_in = next_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data    = data_ff;
   assign rd_data = (rd_pos == MY_INDEX) ? data_ff : 32'd0;

endmodule

/* sv/plid_gather.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plid_gather
// Merges the gated cell words: a registered OR per group of cells, then an OR
// across the groups.
// ----------------------------------------------------------------------------
module plid_gather #(
   parameter int CAPACITY = 128
) (
   input  logic                      clock,
   input  logic [CAPACITY-1:0][31:0] words,
   output logic [31:0]               merged
);

   localparam int GS = plid_pkg::GROUP_SIZE;
   localparam int NG = (CAPACITY + GS - 1) / GS;

   logic [NG-1:0][31:0] grp_ff;
   logic [NG-1:0][31:0] grp_in;

   always_comb begin
      for (int g = 0; g < NG; g++) begin
         grp_in[g] = 32'd0;
         for (int k = 0; k < GS; k++) begin
            if (g * GS + k < CAPACITY) begin
               grp_in[g] = grp_in[g] | words[g * GS + k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      grp_ff <= grp_in;
   end

   always_comb begin
      merged = 32'd0;
      for (int g = 0; g < NG; g++) begin
         merged = merged | grp_ff[g];
      end
   end

endmodule

/* sv/positional_insert_delete_list.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_insert_delete_list
// Ordered list of signed 32-bit values with read, insert and delete by
// position, built as a row of cells that shift together.
// ----------------------------------------------------------------------------
// Each beat on the request side is one operation and yields one response
// beat carrying the status and the entry count after the operation. Insert
// and delete shift every cell in the accept cycle; the response register
// loads after the read position register and the registered group OR of
// the read gather, and no new request is taken until the block is back in
// idle. A new request is taken while the previous response is still
// waiting in the output register. The list is empty after reset.
module positional_insert_delete_list #(
   parameter int CAPACITY = 128
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  plid_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output plid_pkg::rsp_type rsp_payload
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = (CW > 8) ? CW : 8;
   localparam logic [PW-1:0] CAP_W = PW'(CAPACITY);

   plid_pkg::state_type state_ff;
   plid_pkg::state_type state_in;
   logic [CW-1:0]       count_ff;
   logic [CW-1:0]       count_in;
   logic [1:0]          status_ff;
   logic [1:0]          status_in;
   logic                okrd_ff;
   logic [PW-1:0]       rdpos_ff;
   logic                rsp_valid_ff;
   plid_pkg::rsp_type   rsp_ff;
   logic                accept;
   logic                rsp_load;
   logic [PW-1:0]       pos_w;
   logic [PW-1:0]       cnt_w;
   plid_pkg::shift_type shift;
   logic [31:0]         merged;

   logic [CAPACITY-1:0][31:0] cell_data;
   logic [CAPACITY-1:0][31:0] cell_rd;

   assign accept = req_valid && !req_stall;
   assign pos_w  = PW'(req_payload.position);
   assign cnt_w  = PW'(count_ff);

   always_comb begin
      status_in = plid_pkg::ST_BADPOS;
      case (req_payload.opcode)
         plid_pkg::OP_READ: begin
            status_in = (pos_w < cnt_w) ? plid_pkg::ST_OK : plid_pkg::ST_BADPOS;
         end
         plid_pkg::OP_INSERT: begin
            if (cnt_w >= CAP_W) begin
               status_in = plid_pkg::ST_FULL;
            end else if (pos_w > cnt_w) begin
               status_in = plid_pkg::ST_BADPOS;
            end else begin
               status_in = plid_pkg::ST_OK;
            end
         end
         plid_pkg::OP_DELETE: begin
            if (cnt_w == '0) begin
               status_in = plid_pkg::ST_EMPTY;
            end else if (pos_w >= cnt_w) begin
               status_in = plid_pkg::ST_BADPOS;
            end else begin
               status_in = plid_pkg::ST_OK;
            end
         end
         default: begin
            status_in = plid_pkg::ST_BADPOS;
         end
      endcase
   end

   always_comb begin
      shift.ins = accept && (req_payload.opcode == plid_pkg::OP_INSERT) &&
                  (status_in == plid_pkg::ST_OK);
      shift.del = accept && (req_payload.opcode == plid_pkg::OP_DELETE) &&
                  (status_in == plid_pkg::ST_OK);
      count_in  = count_ff;
      if (shift.ins) begin
         count_in = count_ff + CW'(1);
      end else if (shift.del) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_stall = 1'b1;
      rsp_load  = 1'b0;
      case (state_ff)
         plid_pkg::S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               state_in = plid_pkg::S_GATHER;
            end
         end
         plid_pkg::S_GATHER: begin
            state_in = plid_pkg::S_COLLECT;
         end
         plid_pkg::S_COLLECT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = plid_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = plid_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= plid_pkg::S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         okrd_ff   <= (req_payload.opcode == plid_pkg::OP_READ) &&
                      (status_in == plid_pkg::ST_OK);
         rdpos_ff  <= pos_w;
      end
      if (rsp_load) begin
         rsp_ff.status      <= status_ff;
         rsp_ff.read_value  <= okrd_ff ? merged : 32'sd0;
         rsp_ff.entry_count <= 8'(count_ff);
      end
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [31:0] prev_w;
      logic [31:0] next_w;
      if (i == 0) begin : g_first
         assign prev_w = 32'd0;
      end else begin : g_mid
         assign prev_w = cell_data[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign next_w = cell_data[i];
      end else begin : g_rest
         assign next_w = cell_data[i+1];
      end
      plid_cell #(
         .PW    (PW),
         .INDEX (i)
      ) u_cell (
         .clock     (clock),
         .shift     (shift),
         .pos       (pos_w),
         .value     (req_payload.value),
         .prev_data (prev_w),
         .next_data (next_w),
         .rd_pos    (rdpos_ff),
         .data      (cell_data[i]),
         .rd_data   (cell_rd[i])
      );
   end

   plid_gather #(
      .CAPACITY (CAPACITY)
   ) u_gather (
      .clock  (clock),
      .words  (cell_rd),
      .merged (merged)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count exceeds capacity");

   a_accept_gather: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == plid_pkg::S_GATHER)
      else $error("accepted beat did not start the read gather");

   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(count_ff))
      else $error("entry count changed without an accepted beat");

   a_read_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.status != plid_pkg::ST_OK) |-> rsp_ff.read_value == 32'sd0)
      else $error("failed operation returned a nonzero read value");
`endif

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the positional insert/delete list. A shadow list
// kept in a small class predicts status, read value and entry count for
// every accepted request beat and checks each response beat in order. A
// directed opening covers the empty list, ends and middle of the list,
// extreme values and the unused opcode. Random traffic then alternates
// between filling the list to capacity and draining it to empty, mixed with
// reads and out-of-range noise, under random idling on both channels and one
// long response hold-off.
// ----------------------------------------------------------------------------
module testbench;

   localparam int CAPACITY = 128;
   localparam int RANDOM_OPS = 830;
   localparam int QUIET_OPS = 120;
   localparam int LONG_HOLD = 200;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   class list_shadow;
      logic signed [31:0] cells [CAPACITY];
      int unsigned held;
      plid_pkg::rsp_type pending_answers [$];
      int unsigned errors, accepted, checked, peak;
      int unsigned full_hits, empty_hits, badpos_hits;

      function void note_operation(plid_pkg::req_type r);
         plid_pkg::rsp_type e;
         int unsigned p;
         int unsigned i;
         p = 32'(r.position);
         e.status = plid_pkg::ST_OK;
         e.read_value = '0;
         accepted++;
         case (r.opcode)
            plid_pkg::OP_READ: begin
               if (p < held) e.read_value = cells[p];
               else e.status = plid_pkg::ST_BADPOS;
            end
            plid_pkg::OP_INSERT: begin
               if (held >= CAPACITY) begin
                  e.status = plid_pkg::ST_FULL;
               end else if (p > held) begin
                  e.status = plid_pkg::ST_BADPOS;
               end else begin
                  for (i = held; i > p; i--) cells[i] = cells[i - 1];
                  cells[p] = r.value;
                  held++;
               end
            end
            plid_pkg::OP_DELETE: begin
               if (held == 0) begin
                  e.status = plid_pkg::ST_EMPTY;
               end else if (p >= held) begin
                  e.status = plid_pkg::ST_BADPOS;
               end else begin
                  for (i = p; i + 1 < held; i++) cells[i] = cells[i + 1];
                  held--;
               end
            end
            default: e.status = plid_pkg::ST_BADPOS;
         endcase
         case (e.status)
            plid_pkg::ST_FULL: full_hits++;
            plid_pkg::ST_EMPTY: empty_hits++;
            plid_pkg::ST_BADPOS: badpos_hits++;
            default: ;
         endcase
         if (held > peak) peak = held;
         e.entry_count = held[7:0];
         pending_answers.push_back(e);
      endfunction

      function void check_response(plid_pkg::rsp_type a);
         plid_pkg::rsp_type e;
         if (pending_answers.size() == 0) begin
            $error("Response beat with no request waiting: status %0d, value %0d, count %0d.",
                   a.status, a.read_value, a.entry_count);
            errors++;
            return;
         end
         e = pending_answers.pop_front();
         checked++;
         if (a.status !== e.status) begin
            $error("status mismatch: expected %0d, actual %0d", e.status, a.status);
            errors++;
         end
         if (a.read_value !== e.read_value) begin
            $error("read_value mismatch: expected %0d, actual %0d", e.read_value,
                   a.read_value);
            errors++;
         end
         if (a.entry_count !== e.entry_count) begin
            $error("entry_count mismatch: expected %0d, actual %0d", e.entry_count,
                   a.entry_count);
            errors++;
         end
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   plid_pkg::req_type req_payload;
   logic              rsp_valid;
   logic              rsp_stall;
   plid_pkg::rsp_type rsp_payload;
   bit                quiet = 1'b0;
   bit                held_long = 1'b0;
   list_shadow        book;

   positional_insert_delete_list #(.CAPACITY(CAPACITY)) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_payload(rsp_payload)
   );

   always #2 clock = ~clock;

   task automatic send_op(input logic [1:0] opcode, input logic [7:0] position,
                          input logic signed [31:0] value);
      plid_pkg::req_type r;
      r.opcode = opcode;
      r.position = position;
      r.value = value;
      req_valid <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      book.note_operation(r);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
   endtask

   function automatic logic [7:0] pick_position(input int unsigned limit);
      case ($urandom_range(0, 3))
         0: return 8'd0;
         1: return limit[7:0];
         default: return 8'($urandom_range(0, limit));
      endcase
   endfunction

   function automatic logic signed [31:0] pick_value();
      if ($urandom_range(0, 9) != 0) return $urandom;
      case ($urandom_range(0, 3))
         0: return 32'sh7FFFFFFF;
         1: return 32'sh80000000;
         2: return 32'sd0;
         default: return -32'sd1;
      endcase
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) book.check_response(rsp_payload);
   end

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (quiet || reset) begin
            rsp_stall <= 1'b0;
         end else if (!held_long && book.accepted >= 300) begin
            held_long = 1'b1;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD - 1) @(posedge clock);
         end else if ($urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 14) - 1) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      #1_000_000;
      $display("[positional_insert_delete_list] ERROR");
      $finish;
   end

   initial begin
      int unsigned k;
      int unsigned pick;
      int unsigned plateau;
      bit filling;
      bit grow;
      book = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      send_op(plid_pkg::OP_READ, 8'd0, 32'sd0);
      send_op(plid_pkg::OP_DELETE, 8'd0, 32'sd0);
      send_op(plid_pkg::OP_DELETE, 8'd255, -32'sd1);
      send_op(plid_pkg::OP_INSERT, 8'd1, 32'sd5);
      send_op(plid_pkg::OP_INSERT, 8'd0, 32'sh7FFFFFFF);
      send_op(plid_pkg::OP_INSERT, 8'd0, 32'sh80000000);
      send_op(plid_pkg::OP_INSERT, 8'd2, -32'sd1);
      send_op(plid_pkg::OP_INSERT, 8'd1, 32'sd0);
      for (k = 0; k < 4; k++) send_op(plid_pkg::OP_READ, 8'(k), 32'sd0);
      send_op(plid_pkg::OP_READ, 8'd4, 32'sd0);
      send_op(plid_pkg::OP_READ, 8'd255, 32'sd0);
      send_op(OP_UNUSED, 8'd0, $urandom);
      send_op(plid_pkg::OP_INSERT, 8'd5, 32'sd9);
      send_op(plid_pkg::OP_DELETE, 8'd4, 32'sd0);
      send_op(plid_pkg::OP_DELETE, 8'd1, 32'sd0);
      send_op(plid_pkg::OP_DELETE, 8'd2, 32'sd0);
      send_op(plid_pkg::OP_DELETE, 8'd0, 32'sd0);
      send_op(plid_pkg::OP_READ, 8'd0, 32'sd0);

      filling = 1'b1;
      plateau = 0;
      for (k = 0; k < RANDOM_OPS; k++) begin
         if (k >= RANDOM_OPS - QUIET_OPS) quiet = 1'b1;
         if (filling ? book.held == CAPACITY : book.held == 0) begin
            plateau++;
            if (plateau >= 4) begin
               filling = !filling;
               plateau = 0;
            end
         end
         pick = $urandom_range(0, 99);
         grow = (pick < 32) ? !filling : filling;
         if (pick < 8) begin
            send_op(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), pick_value());
         end else if (pick < 22) begin
            send_op(plid_pkg::OP_READ,
                    book.held == 0 ? 8'd0 : pick_position(book.held - 1),
                    pick_value());
         end else if (grow) begin
            send_op(plid_pkg::OP_INSERT, pick_position(book.held), pick_value());
         end else begin
            send_op(plid_pkg::OP_DELETE,
                    book.held == 0 ? 8'd0 : pick_position(book.held - 1),
                    pick_value());
         end
      end

      req_valid <= 1'b0;
      while (book.pending_answers.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
      $display("Ran %0d operations and checked %0d responses; the list peaked at %0d entries.",
               book.accepted, book.checked, book.peak);
      $display("Rejections seen: %0d on a full list, %0d on an empty list, %0d bad position.",
               book.full_hits, book.empty_hits, book.badpos_hits);
      if (book.errors == 0) begin
         $display("[positional_insert_delete_list] OK");
      end else begin
         $display("[positional_insert_delete_list] ERROR");
      end
      $finish;
   end

endmodule

/* files.f */
sv/plid_pkg.sv
sv/plid_cell.sv
sv/plid_gather.sv
sv/positional_insert_delete_list.sv
tb/testbench.sv
